@@ rtl/fqc_pkg.sv @@
// Shared constants and types for the circular-history Q15 FIR filter.
package fqc_pkg;

  // Field widths
  localparam int TAP_W      = 5;
  localparam int SAMPLE_W   = 16;
  localparam int NUM_TAPS_W = 6;
  localparam int ACC_W      = 32;
  localparam int PROD_W     = 2 * SAMPLE_W;
  localparam int IN_DATA_W  = 24;
  localparam int Q_SHIFT    = 15;

  // Defaults
  localparam int                    MAX_TAPS_DEFAULT = 32;
  localparam logic [NUM_TAPS_W-1:0] NUM_TAPS_RESET   = 6'd32;

  // Item kinds carried on tuser
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_COEF   = 1'b1;

  // Control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic clear;  // start a new sum
    logic issue;  // a memory read was issued this cycle
  } mac_ctrl_t;

endpackage

@@ rtl/fir_filter_q15_circular.sv @@
// Direct-form Q15 FIR filter with circular sample history; top level and sequencer.
// A sample item is stored one place on in a circular history, then the filter output is
// summed one tap per cycle: coefficient k times the sample k places back, for the first
// num_taps taps (capped at MAX_TAPS). The next item is not taken until the result of a
// sample item has been loaded into the output register. The single multiply-accumulate
// unit reads one history entry and one coefficient per cycle from two memories; its output is
// accumulator bits 30..15 of a 32-bit wrapping sum. A coefficient item (tuser high) writes
// one tap and gives no result; a tap index at or above MAX_TAPS is dropped. History and
// coefficients read as zero after reset until written. num_taps resets to 32 and is to be
// written by the user through the cfg port only while the block is idle; the block itself
// does not enforce this.
module fir_filter_q15_circular #(
  parameter int MAX_TAPS = fqc_pkg::MAX_TAPS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  // Input items
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [fqc_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // tap_index[4:0], value[20:5], zero pad
  input  logic                              s_axis_tuser,  // op: 0 sample, 1 coefficient
  // Result items
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [fqc_pkg::SAMPLE_W-1:0]      m_axis_tdata,  // filtered_sample[15:0]
  // num_taps register
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fqc_pkg::NUM_TAPS_W-1:0]    cfg_data
);
  import fqc_pkg::*;

  localparam int AW = $clog2(MAX_TAPS);
  localparam int CW = $clog2(MAX_TAPS + 1);
  localparam int TW = (CW > NUM_TAPS_W) ? CW : NUM_TAPS_W;
  localparam int IW = ((AW > TAP_W) ? AW : TAP_W) + 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]            state;
  logic [NUM_TAPS_W-1:0] num_taps;
  logic [AW-1:0]         wp;
  logic [AW-1:0]         wp_next;
  logic [AW-1:0]         pos;
  logic [CW-1:0]         k;
  logic [CW-1:0]         taps_eff;
  logic [TW-1:0]         num_taps_ext;
  logic [IW-1:0]         tap_ext;

  logic                  in_take;
  logic                  in_op;
  logic [TAP_W-1:0]      in_tap;
  logic [SAMPLE_W-1:0]   in_value;
  logic                  sample_we;
  logic                  coef_we;
  logic                  issue;
  logic                  load_out;

  mac_ctrl_t             mac_ctrl;
  logic [SAMPLE_W-1:0]   hist_rdata;
  logic [SAMPLE_W-1:0]   coef_rdata;
  logic [SAMPLE_W-1:0]   mac_result;
  logic                  mac_busy;

  // Input unpacking
  assign in_op    = s_axis_tuser;
  assign in_tap   = s_axis_tdata[TAP_W-1:0];
  assign in_value = s_axis_tdata[TAP_W +: SAMPLE_W];

  assign s_axis_tready = (state == ST_IDLE);
  assign in_take       = s_axis_tvalid & s_axis_tready;
  assign sample_we     = in_take & (in_op == OP_SAMPLE);
  assign tap_ext       = IW'(in_tap);
  assign coef_we       = in_take & (in_op == OP_COEF) & (tap_ext < IW'(MAX_TAPS));

  // Next write position, wrapping at the history length
  assign wp_next = (wp == AW'(MAX_TAPS - 1)) ? '0 : wp + AW'(1);

  // Tap count capped at the capacity
  assign num_taps_ext = TW'(num_taps);
  assign taps_eff     = (num_taps_ext > TW'(MAX_TAPS)) ? CW'(MAX_TAPS) : CW'(num_taps_ext);

  // Configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      num_taps <= NUM_TAPS_RESET;
    end else if (cfg_valid & cfg_ready) begin
      num_taps <= cfg_data;
    end
  end

  assign issue    = (state == ST_RUN) && (k < taps_eff);
  assign load_out = (state == ST_DRAIN) && !mac_busy && (!m_axis_tvalid || m_axis_tready);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      wp    <= '0;
      pos   <= '0;
      k     <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (sample_we) begin
            wp    <= wp_next;
            pos   <= wp_next;
            k     <= '0;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (issue) begin
            k   <= k + CW'(1);
            pos <= (pos == '0) ? AW'(MAX_TAPS - 1) : pos - AW'(1);
          end else begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_axis_tdata <= mac_result;
    end
  end

  // Sample history
  fqc_ram #(
    .DEPTH (MAX_TAPS),
    .WIDTH (SAMPLE_W),
    .AW    (AW)
  ) u_hist (
    .clk   (clk),
    .rst   (rst),
    .we    (sample_we),
    .waddr (wp_next),
    .wdata (in_value),
    .re    (issue),
    .raddr (pos),
    .rdata (hist_rdata)
  );

  // Coefficient store
  fqc_ram #(
    .DEPTH (MAX_TAPS),
    .WIDTH (SAMPLE_W),
    .AW    (AW)
  ) u_coef (
    .clk   (clk),
    .rst   (rst),
    .we    (coef_we),
    .waddr (AW'(tap_ext)),
    .wdata (in_value),
    .re    (issue),
    .raddr (k[AW-1:0]),
    .rdata (coef_rdata)
  );

  // Multiply-accumulate
  assign mac_ctrl.clear = sample_we;
  assign mac_ctrl.issue = issue;

  fqc_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (mac_ctrl),
    .coef   (coef_rdata),
    .sample (hist_rdata),
    .result (mac_result),
    .busy   (mac_busy)
  );

endmodule

@@ rtl/fqc_ram.sv @@
// Single-port-write, single-port-read memory with registered read and per-entry valid bits.
module fqc_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 16,
  parameter int AW    = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid;

  // Entries not yet written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= valid[raddr] ? mem[raddr] : '0;
    end
  end

endmodule

@@ rtl/fqc_mac.sv @@
// Two-stage multiply-accumulate unit: product register, then 32-bit wrapping accumulator.
module fqc_mac (
  input  logic                          clk,
  input  logic                          rst,
  input  fqc_pkg::mac_ctrl_t            ctrl,
  input  logic [fqc_pkg::SAMPLE_W-1:0]  coef,
  input  logic [fqc_pkg::SAMPLE_W-1:0]  sample,
  output logic [fqc_pkg::SAMPLE_W-1:0]  result,
  output logic                          busy
);
  import fqc_pkg::*;

  logic                     d_valid;
  logic                     p_valid;
  logic signed [PROD_W-1:0] product;
  logic [ACC_W-1:0]         acc;

  // Pipeline valid flags follow the memory read latency
  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
      p_valid <= 1'b0;
    end else begin
      d_valid <= ctrl.issue;
      p_valid <= d_valid;
    end
  end

  // Signed 16 x 16 product
  always_ff @(posedge clk) begin
    if (d_valid) begin
      product <= $signed(coef) * $signed(sample);
    end
  end

  // Accumulate modulo 2^32
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc <= '0;
    end else if (p_valid) begin
      acc <= acc + ACC_W'(product);
    end
  end

  assign result = acc[Q_SHIFT +: SAMPLE_W];
  assign busy   = d_valid | p_valid;

endmodule
